FILE: design/krt_pkg.sv
// ----------------------------------------------------------------------------
// krt_pkg
// shared constants, codes and controller/datapath interface types for the
// keyed record table
// ----------------------------------------------------------------------------
package krt_pkg;

    // table geometry
    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W = 32;
    localparam int PAY_W = 32;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DUP    = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_SEARCH,
        CS_SHIFT
    } ctl_state_t;

    // source of the reported position
    typedef enum logic [1:0] {
        POS_NONE,
        POS_COUNT,
        POS_MATCH,
        POS_SAVED
    } pos_sel_t;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       rd_en;
        logic       save_match;
        logic       shift_wr;
        logic       append;
        logic       dec;
        logic       finish;
        logic [1:0] status;
        pos_sel_t   pos_sel;
        logic       pay_en;
    } krt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       match;
        logic       rd_vld;
        logic       ptr_lt_cnt;
        logic       full;
    } krt_stat_t;

endpackage

FILE: design/krt_datapath.sv
// ----------------------------------------------------------------------------
// krt_datapath
// record memory, scan pointer, entry count and result registers
// ----------------------------------------------------------------------------
module krt_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [1:0]                    op,
    input  logic [krt_pkg::KEY_W-1:0]     key,
    input  logic [krt_pkg::PAY_W-1:0]     payload,
    input  krt_pkg::krt_cmd_t             cmd,
    output krt_pkg::krt_stat_t            stat,
    output logic                          done,
    output logic [1:0]                    status,
    output logic [krt_pkg::IDX_W-1:0]     position,
    output logic [krt_pkg::PAY_W-1:0]     found_payload,
    output logic [krt_pkg::CNT_W-1:0]     count
);

    localparam int REC_W = krt_pkg::KEY_W + krt_pkg::PAY_W;

    // key in the upper half, payload in the lower half
    logic [REC_W-1:0] store_mem [krt_pkg::DEPTH];

    logic [1:0]                op_reg;
    logic [krt_pkg::KEY_W-1:0] key_reg;
    logic [krt_pkg::PAY_W-1:0] pay_reg;
    logic [krt_pkg::CNT_W-1:0] ptr_reg;
    logic [krt_pkg::CNT_W-1:0] cnt_reg;
    logic [krt_pkg::CNT_W-1:0] cnt_next;
    logic [REC_W-1:0]          rd_data_reg;
    logic [krt_pkg::IDX_W-1:0] rd_idx_reg;
    logic                      rd_vld_reg;
    logic [krt_pkg::IDX_W-1:0] saved_idx_reg;
    logic                      done_reg;
    logic [1:0]                status_reg;
    logic [krt_pkg::IDX_W-1:0] position_reg;
    logic [krt_pkg::PAY_W-1:0] found_pay_reg;

    logic                      wr_en;
    logic [krt_pkg::IDX_W-1:0] wr_addr;
    logic [REC_W-1:0]          wr_data;
    logic [krt_pkg::IDX_W-1:0] pos_next;
    logic [krt_pkg::KEY_W-1:0] rd_key;
    logic [krt_pkg::PAY_W-1:0] rd_pay;

    assign rd_key = rd_data_reg[REC_W-1:krt_pkg::PAY_W];
    assign rd_pay = rd_data_reg[krt_pkg::PAY_W-1:0];

    // one write a cycle: append at the end, or move a record down one place
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cnt_reg[krt_pkg::IDX_W-1:0];
        wr_data = {key_reg, pay_reg};
        if (cmd.append)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.shift_wr && rd_vld_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = rd_idx_reg - krt_pkg::IDX_W'(1);
            wr_data = rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= store_mem[ptr_reg[krt_pkg::IDX_W-1:0]];
            rd_idx_reg  <= ptr_reg[krt_pkg::IDX_W-1:0];
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.append)
        begin
            cnt_next = cnt_reg + krt_pkg::CNT_W'(1);
        end
        else if (cmd.dec)
        begin
            cnt_next = cnt_reg - krt_pkg::CNT_W'(1);
        end
    end

    always_comb
    begin
        case (cmd.pos_sel)
            krt_pkg::POS_COUNT: pos_next = cnt_reg[krt_pkg::IDX_W-1:0];
            krt_pkg::POS_MATCH: pos_next = rd_idx_reg;
            krt_pkg::POS_SAVED: pos_next = saved_idx_reg;
            default:            pos_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
            ptr_reg    <= '0;
            op_reg     <= '0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            rd_vld_reg <= cmd.rd_en;
            done_reg   <= cmd.finish;
            if (cmd.load)
            begin
                ptr_reg <= '0;
                op_reg  <= op;
            end
            else if (cmd.save_match)
            begin
                ptr_reg <= krt_pkg::CNT_W'(rd_idx_reg) + krt_pkg::CNT_W'(1);
            end
            else if (cmd.rd_en)
            begin
                ptr_reg <= ptr_reg + krt_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= key;
            pay_reg <= payload;
        end
        if (cmd.save_match)
        begin
            saved_idx_reg <= rd_idx_reg;
        end
        if (cmd.finish)
        begin
            status_reg    <= cmd.status;
            position_reg  <= pos_next;
            found_pay_reg <= cmd.pay_en ? rd_pay : '0;
        end
    end

    assign stat.op         = op_reg;
    assign stat.match      = rd_vld_reg && (rd_key == key_reg);
    assign stat.rd_vld     = rd_vld_reg;
    assign stat.ptr_lt_cnt = ptr_reg < cnt_reg;
    assign stat.full       = cnt_reg == krt_pkg::CNT_W'(krt_pkg::DEPTH);

    assign done          = done_reg;
    assign status        = status_reg;
    assign position      = position_reg;
    assign found_payload = found_pay_reg;
    assign count         = cnt_reg;

endmodule

FILE: design/krt_ctrl.sv
// ----------------------------------------------------------------------------
// krt_ctrl
// sequencer for search, append and shift-down compaction
// ----------------------------------------------------------------------------
module krt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  krt_pkg::krt_stat_t stat,
    output krt_pkg::krt_cmd_t  cmd,
    output logic               busy
);

    krt_pkg::ctl_state_t state_reg;
    krt_pkg::ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= krt_pkg::CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = krt_pkg::ST_ABSENT;
        cmd.pos_sel = krt_pkg::POS_NONE;
        case (state_reg)
            krt_pkg::CS_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = krt_pkg::CS_SEARCH;
                end
            end
            krt_pkg::CS_SEARCH:
            begin
                if (stat.match)
                begin
                    case (stat.op)
                        krt_pkg::OP_INSERT:
                        begin
                            cmd.finish = 1'b1;
                            cmd.status = krt_pkg::ST_DUP;
                            state_next = krt_pkg::CS_IDLE;
                        end
                        krt_pkg::OP_REMOVE:
                        begin
                            cmd.save_match = 1'b1;
                            state_next     = krt_pkg::CS_SHIFT;
                        end
                        krt_pkg::OP_LOOKUP:
                        begin
                            cmd.finish  = 1'b1;
                            cmd.status  = krt_pkg::ST_OK;
                            cmd.pos_sel = krt_pkg::POS_MATCH;
                            cmd.pay_en  = 1'b1;
                            state_next  = krt_pkg::CS_IDLE;
                        end
                        default:
                        begin
                            cmd.finish = 1'b1;
                            state_next = krt_pkg::CS_IDLE;
                        end
                    endcase
                end
                else if (stat.ptr_lt_cnt)
                begin
                    cmd.rd_en = 1'b1;
                end
                else if (!stat.rd_vld)
                begin
                    // scan exhausted, key not present
                    cmd.finish = 1'b1;
                    state_next = krt_pkg::CS_IDLE;
                    if (stat.op == krt_pkg::OP_INSERT)
                    begin
                        if (stat.full)
                        begin
                            cmd.status = krt_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.append  = 1'b1;
                            cmd.status  = krt_pkg::ST_OK;
                            cmd.pos_sel = krt_pkg::POS_COUNT;
                        end
                    end
                end
            end
            krt_pkg::CS_SHIFT:
            begin
                cmd.shift_wr = 1'b1;
                if (stat.ptr_lt_cnt)
                begin
                    cmd.rd_en = 1'b1;
                end
                else if (!stat.rd_vld)
                begin
                    cmd.dec     = 1'b1;
                    cmd.finish  = 1'b1;
                    cmd.status  = krt_pkg::ST_OK;
                    cmd.pos_sel = krt_pkg::POS_SAVED;
                    state_next  = krt_pkg::CS_IDLE;
                end
            end
            default:
            begin
                state_next = krt_pkg::CS_IDLE;
            end
        endcase
    end

    assign busy = state_reg != krt_pkg::CS_IDLE;

endmodule

FILE: design/keyed_record_table.sv
// ----------------------------------------------------------------------------
// keyed_record_table
// packed table of key/payload records with linear search and gap closing
// ----------------------------------------------------------------------------
// usage
//   a command beat (op, key, payload) is taken on a clock edge where start is
//   high and busy is low. busy stays high while the command is worked on.
//   each command gives exactly one result beat: done is high for one cycle
//   and status, position, found_payload and count are valid in that cycle.
//   the receiver cannot stall; the result must be taken when done is high.
// operation
//   the search reads one record per cycle through the single registered
//   read port of the record memory, until the key is hit or every entry
//   below the count has been read. a remove then moves each later record
//   down one place. done rises in the cycle that busy falls, and a new
//   command can be given in the cycle that done is high.
// reset
//   rst_n clears the entry count and the sequencer; the record memory is
//   not cleared, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module keyed_record_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [1:0]                    op,
    input  logic [krt_pkg::KEY_W-1:0]     key,
    input  logic [krt_pkg::PAY_W-1:0]     payload,
    output logic                          busy,
    output logic                          done,
    output logic [1:0]                    status,
    output logic [krt_pkg::IDX_W-1:0]     position,
    output logic [krt_pkg::PAY_W-1:0]     found_payload,
    output logic [krt_pkg::CNT_W-1:0]     count
);

    // command and status between sequencer and datapath
    krt_pkg::krt_cmd_t  cmd;
    krt_pkg::krt_stat_t stat;

    // sequencer: idle, search scan, shift-down compaction
    krt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // record memory, scan pointer, count and result registers
    krt_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .key           (key),
        .payload       (payload),
        .cmd           (cmd),
        .stat          (stat),
        .done          (done),
        .status        (status),
        .position      (position),
        .found_payload (found_payload),
        .count         (count)
    );

endmodule
